/* hw/rtl/pss_pkg.sv */
// Shared constants and types for the pressure shock switch.
// No dependencies; imported by pss_lane and pressure_shock_switch_unit.
`timescale 1ns / 1ps

package pss_pkg;

  // blend weight is always unsigned Q0.16
  localparam int EPS_BITS = 16;
  localparam logic [EPS_BITS:0] EPS_ONE = {1'b1, {EPS_BITS{1'b0}}};
  localparam logic [EPS_BITS-1:0] EPS_RESET = 16'd66;

  // one lane per axis: i, j, k
  localparam int LANES = 3;

  typedef struct packed {
    logic zero;   // denominator is zero
    logic sat;    // ratio is 1.0 or more
  } pss_flags_t;

endpackage

/* hw/rtl/pss_lane.sv */
// One axis of the shock switch: difference terms, blend multipliers, restoring divider.
// Depends on pss_pkg. Fully pipelined, advances when adv is high.
`timescale 1ns / 1ps

module pss_lane #(
  parameter int PRESSURE_BITS = 32,
  parameter int FRACTION_BITS = 16
) (
  input  logic                          clk,
  input  logic                          adv,
  input  logic [pss_pkg::EPS_BITS-1:0]  eps,
  input  logic [PRESSURE_BITS-1:0]      p,
  input  logic [PRESSURE_BITS-1:0]      a,
  input  logic [PRESSURE_BITS-1:0]      b,
  output logic [FRACTION_BITS:0]        ratio
);
  import pss_pkg::*;

  localparam int P  = PRESSURE_BITS;
  localparam int F  = FRACTION_BITS;
  localparam int SW = P + 1;              // a+b, 2p, |a-2p+b|, T
  localparam int UW = P + 2;              // U = a+2p+b
  localparam int WW = EPS_BITS + 1;       // 1 - eps
  localparam int PW = P + EPS_BITS + 2;   // each blend product
  localparam int DW = PW + 1;             // denominator
  localparam int NW = SW + EPS_BITS;      // numerator
  localparam logic [F:0] RATIO_ONE = {1'b1, {F{1'b0}}};

  // stage 0: difference terms
  logic [SW-1:0] sum_ab, two_p, n0, t0;
  logic [P-1:0]  dap, dpb;
  logic [UW-1:0] u0;
  logic [WW-1:0] w0;

  always_comb begin
    sum_ab = {1'b0, a} + {1'b0, b};
    two_p  = {p, 1'b0};
    n0     = (sum_ab >= two_p) ? (sum_ab - two_p) : (two_p - sum_ab);
    dap    = (a >= p) ? (a - p) : (p - a);
    dpb    = (p >= b) ? (p - b) : (b - p);
    t0     = {1'b0, dap} + {1'b0, dpb};
    u0     = {1'b0, sum_ab} + {1'b0, two_p};
    w0     = EPS_ONE - {1'b0, eps};
  end

  logic [SW-1:0]       s0_n, s0_t;
  logic [UW-1:0]       s0_u;
  logic [WW-1:0]       s0_w;
  logic [EPS_BITS-1:0] s0_e;

  always_ff @(posedge clk) begin
    if (adv) begin
      s0_n <= n0;
      s0_t <= t0;
      s0_u <= u0;
      s0_w <= w0;
      s0_e <= eps;
    end
  end

  // stage 1: blend products, numerator scaled by 2^16
  logic [PW-1:0] s1_pt, s1_pu;
  logic [NW-1:0] s1_num;

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_pt  <= PW'(s0_t) * PW'(s0_w);
      s1_pu  <= PW'(s0_u) * PW'(s0_e);
      s1_num <= {s0_n, {EPS_BITS{1'b0}}};
    end
  end

  // stage 2: denominator
  logic [DW-1:0] s2_den;
  logic [NW-1:0] s2_num;

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_den <= DW'(s1_pt) + DW'(s1_pu);
      s2_num <= s1_num;
    end
  end

  // stage 3 and divider pipeline: index 0 is the compare stage
  logic [DW-1:0] rem   [0:F-1];
  logic [DW-1:0] den   [0:F-1];
  logic [F-1:0]  quo   [1:F];
  pss_flags_t    flags [0:F];

  always_ff @(posedge clk) begin
    if (adv) begin
      flags[0].zero <= (s2_den == '0);
      flags[0].sat  <= (DW'(s2_num) >= s2_den);
      rem[0]        <= DW'(s2_num);
      den[0]        <= s2_den;
    end
  end

  for (genvar k = 0; k < F; k++) begin : g_div
    logic [DW:0]  rem2;
    logic         ge;
    logic [F-1:0] q_in;

    if (k == 0) begin : g_first
      assign q_in = '0;
    end else begin : g_rest
      assign q_in = quo[k];
    end

    assign rem2 = {rem[k], 1'b0};
    assign ge   = (rem2 >= {1'b0, den[k]});

    always_ff @(posedge clk) begin
      if (adv) begin
        quo[k+1]   <= {q_in[F-2:0], ge};
        flags[k+1] <= flags[k];
      end
    end

    if (k < F - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (adv) begin
          rem[k+1] <= ge ? DW'(rem2 - {1'b0, den[k]}) : DW'(rem2);
          den[k+1] <= den[k];
        end
      end
    end
  end

  always_comb begin
    priority if (flags[F].zero) ratio = '0;
    else if (flags[F].sat)      ratio = RATIO_ONE;
    else                        ratio = {1'b0, quo[F]};
  end

endmodule

/* hw/rtl/pressure_shock_switch_unit.sv */
// Top level of the pressure shock switch: three axis lanes, merge and output skid.
// Depends on pss_pkg and pss_lane.
`timescale 1ns / 1ps
//
//  channel  | direction | payload                                   | handshake
//  ---------+-----------+-------------------------------------------+----------------------
//  s_axis   | in        | center + six neighbor pressures           | tvalid / tready
//  m_axis   | out       | switch_i, switch_j, switch_k (Q1.16)      | tvalid / tready
//  cfg      | in        | blend_eps, Q0.16                          | cfg_we, no wait
//
//  One item per cycle sustained while the output is not stalled; an accepted item passes
//  through four front stages, the first loaded at accept, then one restoring-divider
//  stage per quotient bit, then the output register. The divider depth sets the latency, not the rate.
//  rst is synchronous: clears valid bits and the skid, blend_eps returns to 66.
//  The whole pipeline stalls only when the output register and the skid are both full;
//  s_axis_tready comes from a register, not from m_axis_tready.
//  A zero denominator yields 0; a ratio of 1.0 or more yields exactly 1.0.

module pressure_shock_switch_unit #(
  parameter int PRESSURE_BITS = 32,
  parameter int FRACTION_BITS = 16
) (
  input  logic                                       clk,
  input  logic                                       rst,
  input  logic                                       cfg_we,
  input  logic [pss_pkg::EPS_BITS-1:0]               cfg_wdata,
  input  logic                                       s_axis_tvalid,
  output logic                                       s_axis_tready,
  // low to high: p_center, p_i_plus, p_i_minus, p_j_plus, p_j_minus, p_k_plus, p_k_minus
  input  logic [((7*PRESSURE_BITS+7)/8)*8-1:0]       s_axis_tdata,
  output logic                                       m_axis_tvalid,
  input  logic                                       m_axis_tready,
  // low to high: switch_i, switch_j, switch_k
  output logic [((3*(FRACTION_BITS+1)+7)/8)*8-1:0]   m_axis_tdata
);
  import pss_pkg::*;

  localparam int P      = PRESSURE_BITS;
  localparam int F      = FRACTION_BITS;
  localparam int RW     = F + 1;
  localparam int MW     = LANES * RW;
  localparam int OUT_TW = ((MW + 7) / 8) * 8;
  localparam int LAT    = F + 4;           // lane register stages
  localparam logic [RW-1:0] RATIO_ONE = {1'b1, {F{1'b0}}};

  // config register
  logic [EPS_BITS-1:0] blend_eps;

  always_ff @(posedge clk) begin
    if (rst) begin
      blend_eps <= EPS_RESET;
    end else if (cfg_we) begin
      blend_eps <= cfg_wdata;
    end
  end

  // pipeline control: whole pipe moves while the skid is empty
  logic           skid_valid;
  logic           out_valid;
  logic           adv;
  logic [LAT-1:0] vld;
  logic           pipe_take;

  assign adv           = !skid_valid;
  assign s_axis_tready = adv;
  assign pipe_take     = vld[LAT-1] && adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[LAT-2:0], s_axis_tvalid};
    end
  end

  // lanes
  logic [P-1:0]  p_center;
  logic [RW-1:0] lane_ratio [0:LANES-1];

  assign p_center = s_axis_tdata[P-1:0];

  for (genvar l = 0; l < LANES; l++) begin : g_lane
    pss_lane #(
      .PRESSURE_BITS (P),
      .FRACTION_BITS (F)
    ) u_lane (
      .clk   (clk),
      .adv   (adv),
      .eps   (blend_eps),
      .p     (p_center),
      .a     (s_axis_tdata[(2*l+1)*P +: P]),
      .b     (s_axis_tdata[(2*l+2)*P +: P]),
      .ratio (lane_ratio[l])
    );
  end

  // merge the three axes into one result item
  logic [MW-1:0] merged;

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      merged[l*RW +: RW] = lane_ratio[l];
    end
  end

  // output register plus skid
  logic [MW-1:0] out_data, skid_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || m_axis_tready) begin
      if (skid_valid) begin
        out_data   <= skid_data;
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_data  <= merged;
        out_valid <= pipe_take;
      end
    end else if (pipe_take) begin
      skid_data  <= merged;
      skid_valid <= 1'b1;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = OUT_TW'(out_data);

  // checks
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid holds an item while the output register is empty");

  a_ratio_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data[0*RW +: RW] <= RATIO_ONE) && (out_data[1*RW +: RW] <= RATIO_ONE)
                  && (out_data[2*RW +: RW] <= RATIO_ONE))
    else $error("switch ratio above 1.0");

  a_skid_holds: assert property (@(posedge clk) disable iff (rst)
    (skid_valid && !m_axis_tready) |=> skid_valid)
    else $error("skid item dropped while output stalled");

  a_exit_lands: assert property (@(posedge clk) disable iff (rst)
    pipe_take |=> out_valid)
    else $error("item leaving the lanes was lost");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> out_valid)
    else $error("input stalled with an empty output register");

endmodule
